### src/acm_pkg.sv
// Shared types and constants for the channel up/down mixer.
// No dependencies; used by every module under src.
package acm_pkg;

    localparam int NCH    = 6;
    localparam int SMP_W  = 24;
    localparam int PROD_W = 39;
    localparam int ACC_W  = 42;
    localparam int CNT_W  = 3;
    localparam int IDX_W  = 2;

    typedef logic signed [SMP_W-1:0]  sample_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [ACC_W-1:0]  acc_t;
    typedef logic [CNT_W-1:0]         count_t;
    typedef logic [IDX_W-1:0]         reg_idx_t;
    typedef logic [2:0]               gain_t;

    localparam gain_t GAIN_ZERO    = 3'd0;
    localparam gain_t GAIN_ONE     = 3'd1;
    localparam gain_t GAIN_HALF    = 3'd2;
    localparam gain_t GAIN_QUARTER = 3'd3;
    localparam gain_t GAIN_RSQRT2  = 3'd4;

    localparam reg_idx_t REG_SRC_CH   = 2'd0;
    localparam reg_idx_t REG_DST_CH   = 2'd1;
    localparam reg_idx_t REG_DISCRETE = 2'd2;

    localparam count_t CNT_MAX   = 3'd6;
    localparam count_t CNT_RESET = 3'd2;

    // sqrt(0.5) in Q15
    localparam prod_t RSQRT2_Q15 = 39'sd23170;
    localparam acc_t  ROUND_HALF = 42'sd16384;

    localparam sample_t S24_MAX = 24'sh7FFFFF;
    localparam sample_t S24_MIN = 24'sh800000;

    typedef struct packed {
        gain_t [NCH-1:0] gain;
        logic            den;
    } lane_cfg_t;

endpackage

### src/acm_cfg.sv
// Configuration registers and gain matrix decoder.
// Depends on acm_pkg.
module acm_cfg (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  acm_pkg::reg_idx_t                     cfg_index,
    input  acm_pkg::count_t                       cfg_data,
    output acm_pkg::lane_cfg_t [acm_pkg::NCH-1:0] lane_cfg
);

    acm_pkg::count_t src_cnt_reg;
    acm_pkg::count_t dst_cnt_reg;
    logic            disc_reg;
    acm_pkg::count_t ns;
    acm_pkg::count_t nd;
    logic            hit;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_cnt_reg <= acm_pkg::CNT_RESET;
            dst_cnt_reg <= acm_pkg::CNT_RESET;
            disc_reg    <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                acm_pkg::REG_SRC_CH:   src_cnt_reg <= cfg_data;
                acm_pkg::REG_DST_CH:   dst_cnt_reg <= cfg_data;
                acm_pkg::REG_DISCRETE: disc_reg    <= cfg_data[0];
                default:               ;
            endcase
        end
    end

    // count of seven acts as six
    assign ns = (src_cnt_reg > acm_pkg::CNT_MAX) ? acm_pkg::CNT_MAX : src_cnt_reg;
    assign nd = (dst_cnt_reg > acm_pkg::CNT_MAX) ? acm_pkg::CNT_MAX : dst_cnt_reg;

    always_comb
    begin
        hit = 1'b0;
        for (int d = 0; d < acm_pkg::NCH; d++)
        begin
            lane_cfg[d].den  = (acm_pkg::count_t'(d) < nd);
            lane_cfg[d].gain = '0;
        end
        if (!disc_reg && ns != nd)
        begin
            hit = 1'b1;
            unique case ({ns, nd})
                {3'd1, 3'd2}, {3'd1, 3'd4}:
                begin
                    lane_cfg[0].gain[0] = acm_pkg::GAIN_ONE;
                    lane_cfg[1].gain[0] = acm_pkg::GAIN_ONE;
                end
                {3'd1, 3'd6}:
                begin
                    lane_cfg[2].gain[0] = acm_pkg::GAIN_ONE;
                end
                {3'd2, 3'd4}, {3'd2, 3'd6}:
                begin
                    lane_cfg[0].gain[0] = acm_pkg::GAIN_ONE;
                    lane_cfg[1].gain[1] = acm_pkg::GAIN_ONE;
                end
                {3'd4, 3'd6}:
                begin
                    lane_cfg[0].gain[0] = acm_pkg::GAIN_ONE;
                    lane_cfg[1].gain[1] = acm_pkg::GAIN_ONE;
                    lane_cfg[4].gain[2] = acm_pkg::GAIN_ONE;
                    lane_cfg[5].gain[3] = acm_pkg::GAIN_ONE;
                end
                {3'd2, 3'd1}:
                begin
                    lane_cfg[0].gain[0] = acm_pkg::GAIN_HALF;
                    lane_cfg[0].gain[1] = acm_pkg::GAIN_HALF;
                end
                {3'd4, 3'd1}:
                begin
                    lane_cfg[0].gain[0] = acm_pkg::GAIN_QUARTER;
                    lane_cfg[0].gain[1] = acm_pkg::GAIN_QUARTER;
                    lane_cfg[0].gain[2] = acm_pkg::GAIN_QUARTER;
                    lane_cfg[0].gain[3] = acm_pkg::GAIN_QUARTER;
                end
                {3'd6, 3'd1}:
                begin
                    lane_cfg[0].gain[0] = acm_pkg::GAIN_RSQRT2;
                    lane_cfg[0].gain[1] = acm_pkg::GAIN_RSQRT2;
                    lane_cfg[0].gain[2] = acm_pkg::GAIN_ONE;
                    lane_cfg[0].gain[4] = acm_pkg::GAIN_HALF;
                    lane_cfg[0].gain[5] = acm_pkg::GAIN_HALF;
                end
                {3'd4, 3'd2}:
                begin
                    lane_cfg[0].gain[0] = acm_pkg::GAIN_HALF;
                    lane_cfg[0].gain[2] = acm_pkg::GAIN_HALF;
                    lane_cfg[1].gain[1] = acm_pkg::GAIN_HALF;
                    lane_cfg[1].gain[3] = acm_pkg::GAIN_HALF;
                end
                {3'd6, 3'd2}:
                begin
                    lane_cfg[0].gain[0] = acm_pkg::GAIN_ONE;
                    lane_cfg[0].gain[2] = acm_pkg::GAIN_RSQRT2;
                    lane_cfg[0].gain[4] = acm_pkg::GAIN_RSQRT2;
                    lane_cfg[1].gain[1] = acm_pkg::GAIN_ONE;
                    lane_cfg[1].gain[2] = acm_pkg::GAIN_RSQRT2;
                    lane_cfg[1].gain[5] = acm_pkg::GAIN_RSQRT2;
                end
                {3'd6, 3'd4}:
                begin
                    lane_cfg[0].gain[0] = acm_pkg::GAIN_ONE;
                    lane_cfg[0].gain[2] = acm_pkg::GAIN_RSQRT2;
                    lane_cfg[1].gain[1] = acm_pkg::GAIN_ONE;
                    lane_cfg[1].gain[2] = acm_pkg::GAIN_RSQRT2;
                    lane_cfg[2].gain[4] = acm_pkg::GAIN_ONE;
                    lane_cfg[3].gain[5] = acm_pkg::GAIN_ONE;
                end
                default: hit = 1'b0;
            endcase
        end
        // identity over the common channels
        if (!hit)
        begin
            for (int i = 0; i < acm_pkg::NCH; i++)
            begin
                if (acm_pkg::count_t'(i) < ns && acm_pkg::count_t'(i) < nd)
                    lane_cfg[i].gain[i] = acm_pkg::GAIN_ONE;
            end
        end
    end

    a_den_thermo: assert property (@(posedge clk) disable iff (!rst_n)
        (!lane_cfg[5].den || lane_cfg[4].den) && (!lane_cfg[1].den || lane_cfg[0].den))
        else $error("destination enables not contiguous");

    a_unused_row_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (lane_cfg[5].den || lane_cfg[5].gain == '0) &&
        (lane_cfg[2].den || lane_cfg[2].gain == '0))
        else $error("gain on a disabled destination channel");

    a_discrete_diag: assert property (@(posedge clk) disable iff (!rst_n)
        disc_reg |-> (lane_cfg[0].gain[1] == acm_pkg::GAIN_ZERO &&
                      lane_cfg[1].gain[0] == acm_pkg::GAIN_ZERO &&
                      lane_cfg[2].gain[0] == acm_pkg::GAIN_ZERO &&
                      lane_cfg[0].gain[2] == acm_pkg::GAIN_ZERO))
        else $error("off-diagonal gain in discrete mode");

endmodule

### src/acm_lane.sv
// One destination channel lane: gain select, partial sums, round and saturate.
// Depends on acm_pkg.
module acm_lane (
    input  logic                                clk,
    input  logic                                en,
    input  acm_pkg::lane_cfg_t                  cfg,
    input  acm_pkg::sample_t [acm_pkg::NCH-1:0] src,
    input  acm_pkg::prod_t   [acm_pkg::NCH-1:0] srt,
    input  acm_pkg::sample_t                    dst,
    output acm_pkg::sample_t                    res,
    output logic                                sat
);

    acm_pkg::acc_t [acm_pkg::NCH-1:0] term;
    acm_pkg::acc_t    a_next;
    acm_pkg::acc_t    b_next;
    acm_pkg::acc_t    c_next;
    acm_pkg::acc_t    a_reg;
    acm_pkg::acc_t    b_reg;
    acm_pkg::acc_t    c_reg;
    acm_pkg::acc_t    sum;
    logic signed [acm_pkg::ACC_W-16:0] rnd;
    acm_pkg::sample_t res_next;
    logic             sat_next;
    acm_pkg::sample_t res_reg;
    logic             sat_reg;

    always_comb
    begin
        for (int s = 0; s < acm_pkg::NCH; s++)
        begin
            unique case (cfg.gain[s])
                acm_pkg::GAIN_ONE:
                    term[s] = $signed({{3{src[s][23]}}, src[s], 15'b0});
                acm_pkg::GAIN_HALF:
                    term[s] = $signed({{4{src[s][23]}}, src[s], 14'b0});
                acm_pkg::GAIN_QUARTER:
                    term[s] = $signed({{5{src[s][23]}}, src[s], 13'b0});
                acm_pkg::GAIN_RSQRT2:
                    term[s] = $signed({{3{srt[s][38]}}, srt[s]});
                default:
                    term[s] = '0;
            endcase
        end
    end

    assign a_next = term[0] + term[1] + term[2];
    assign b_next = term[3] + term[4] + term[5];
    assign c_next = cfg.den ? ($signed({{3{dst[23]}}, dst, 15'b0}) + acm_pkg::ROUND_HALF)
                            : acm_pkg::ROUND_HALF;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg <= a_next;
            b_reg <= b_next;
            c_reg <= c_next;
        end
    end

    // floor by dropping the low 15 bits, then clip to 24 bits
    assign sum = a_reg + b_reg + c_reg;
    assign rnd = sum[acm_pkg::ACC_W-1:15];

    always_comb
    begin
        if (rnd[26:23] == 4'b0000 || rnd[26:23] == 4'b1111)
        begin
            res_next = rnd[23:0];
            sat_next = 1'b0;
        end
        else
        begin
            res_next = rnd[26] ? acm_pkg::S24_MIN : acm_pkg::S24_MAX;
            sat_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
            sat_reg <= sat_next;
        end
    end

    assign res = res_reg;
    assign sat = sat_reg;

endmodule

### src/acm_merge.sv
// Merge stage: collects lane results and clip flags into the output register.
// Depends on acm_pkg.
module acm_merge (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                lane_valid,
    input  acm_pkg::sample_t [acm_pkg::NCH-1:0] lane_res,
    input  logic             [acm_pkg::NCH-1:0] lane_sat,
    output logic                                out_valid,
    output acm_pkg::sample_t [acm_pkg::NCH-1:0] out_res,
    output logic                                out_sat
);

    logic                                out_valid_reg;
    acm_pkg::sample_t [acm_pkg::NCH-1:0] out_res_reg;
    logic                                out_sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= lane_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_res_reg <= lane_res;
            out_sat_reg <= |lane_sat;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;
    assign out_sat   = out_sat_reg;

endmodule

### src/audio_channel_up_down_mixer.sv
// Top level of the audio channel up/down mixer: input stage, six lanes, merge.
// Depends on acm_pkg, acm_cfg, acm_lane, acm_merge.
//
//  channel | handshake              | payload
//  --------+------------------------+-------------------------------------
//  in      | in_valid / in_ready    | src_ch0..5, dst_ch0..5 (s24)
//  out     | out_valid / out_ready  | out_ch0..5 (s24), saturated
//  cfg     | cfg_valid / cfg_ready  | cfg_index (2b), cfg_data (3b)
//
// One frame per clock unless the output stalls. Stages: input/multiply,
// partial sums, round/clip, merge register. The sqrt(0.5) gain uses one
// constant multiplier per source channel in the input stage.
// Reset clears all valid flags and loads 2/2/speakers into the config.
// When out_ready is low with a result held, the whole pipe stalls and
// in_ready drops; the pipe keeps advancing while the output is empty.
module audio_channel_up_down_mixer (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [23:0]      src_ch0,
    input  logic signed [23:0]      src_ch1,
    input  logic signed [23:0]      src_ch2,
    input  logic signed [23:0]      src_ch3,
    input  logic signed [23:0]      src_ch4,
    input  logic signed [23:0]      src_ch5,
    input  logic signed [23:0]      dst_ch0,
    input  logic signed [23:0]      dst_ch1,
    input  logic signed [23:0]      dst_ch2,
    input  logic signed [23:0]      dst_ch3,
    input  logic signed [23:0]      dst_ch4,
    input  logic signed [23:0]      dst_ch5,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [23:0]      out_ch0,
    output logic signed [23:0]      out_ch1,
    output logic signed [23:0]      out_ch2,
    output logic signed [23:0]      out_ch3,
    output logic signed [23:0]      out_ch4,
    output logic signed [23:0]      out_ch5,
    output logic                    saturated,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [1:0]              cfg_index,
    input  logic [2:0]              cfg_data
);

    acm_pkg::lane_cfg_t [acm_pkg::NCH-1:0] lane_cfg;
    acm_pkg::sample_t   [acm_pkg::NCH-1:0] src_in;
    acm_pkg::sample_t   [acm_pkg::NCH-1:0] dst_in;
    acm_pkg::sample_t   [acm_pkg::NCH-1:0] src_reg;
    acm_pkg::sample_t   [acm_pkg::NCH-1:0] dst_reg;
    acm_pkg::prod_t     [acm_pkg::NCH-1:0] srt_next;
    acm_pkg::prod_t     [acm_pkg::NCH-1:0] srt_reg;
    acm_pkg::sample_t   [acm_pkg::NCH-1:0] lane_res;
    logic               [acm_pkg::NCH-1:0] lane_sat;
    acm_pkg::sample_t   [acm_pkg::NCH-1:0] out_res;
    logic en;
    logic v1_reg;
    logic v2_reg;
    logic v3_reg;

    assign src_in = {src_ch5, src_ch4, src_ch3, src_ch2, src_ch1, src_ch0};
    assign dst_in = {dst_ch5, dst_ch4, dst_ch3, dst_ch2, dst_ch1, dst_ch0};

    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    acm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .lane_cfg  (lane_cfg)
    );

    always_comb
    begin
        for (int s = 0; s < acm_pkg::NCH; s++)
            srt_next[s] = $signed({{15{src_in[s][23]}}, src_in[s]}) * acm_pkg::RSQRT2_Q15;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            src_reg <= src_in;
            dst_reg <= dst_in;
            srt_reg <= srt_next;
        end
    end

    for (genvar d = 0; d < acm_pkg::NCH; d++)
    begin : g_lane
        acm_lane u_lane (
            .clk (clk),
            .en  (en),
            .cfg (lane_cfg[d]),
            .src (src_reg),
            .srt (srt_reg),
            .dst (dst_reg[d]),
            .res (lane_res[d]),
            .sat (lane_sat[d])
        );
    end

    acm_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .lane_valid (v3_reg),
        .lane_res   (lane_res),
        .lane_sat   (lane_sat),
        .out_valid  (out_valid),
        .out_res    (out_res),
        .out_sat    (saturated)
    );

    assign out_ch0 = out_res[0];
    assign out_ch1 = out_res[1];
    assign out_ch2 = out_res[2];
    assign out_ch3 = out_res[3];
    assign out_ch4 = out_res[4];
    assign out_ch5 = out_res[5];

    a_sat_extreme: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && saturated) |->
            (out_ch0 == acm_pkg::S24_MAX || out_ch0 == acm_pkg::S24_MIN ||
             out_ch1 == acm_pkg::S24_MAX || out_ch1 == acm_pkg::S24_MIN ||
             out_ch2 == acm_pkg::S24_MAX || out_ch2 == acm_pkg::S24_MIN ||
             out_ch3 == acm_pkg::S24_MAX || out_ch3 == acm_pkg::S24_MIN ||
             out_ch4 == acm_pkg::S24_MAX || out_ch4 == acm_pkg::S24_MIN ||
             out_ch5 == acm_pkg::S24_MAX || out_ch5 == acm_pkg::S24_MIN))
        else $error("clip flag set with no clipped channel");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> v1_reg)
        else $error("accepted beat lost at input stage");

    a_out_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(v3_reg))
        else $error("output valid without a beat in the last lane stage");

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps
// Testbench for audio_channel_up_down_mixer: directed layout pairs, then random phases.
// A mix checker predicts each frame and checks every output beat. Depends on acm_pkg.
module testbench;
    import acm_pkg::*;

    localparam int          Q15_ONE       = 32768;
    localparam int          Q15_HALF      = 16384;
    localparam int          Q15_QUARTER   = 8192;
    localparam int          Q15_RSQRT2    = 23170;
    localparam longint      ROUND_Q15     = 16384;
    localparam count_t      MONO          = 3'd1;
    localparam count_t      STEREO        = 3'd2;
    localparam count_t      QUAD          = 3'd4;
    localparam count_t      SURR51        = 3'd6;
    localparam count_t      MODE_SPEAKERS = 3'd0;
    localparam count_t      MODE_DISCRETE = 3'd1;
    localparam reg_idx_t    REG_UNUSED    = 2'd3;
    localparam int          ITEM_TARGET   = 600;
    localparam int          SETTLE_CYCLES = 8;
    localparam int unsigned CYCLE_LIMIT   = 200000;

    typedef struct packed {
        sample_t [NCH-1:0] src;
        sample_t [NCH-1:0] dst;
    } frame_t;

    typedef struct packed {
        sample_t [NCH-1:0] ch;
        logic              clip;
    } mix_t;

    typedef struct packed {
        count_t src;
        count_t dst;
        count_t mode_word;
    } mix_setting_t;

    class mix_checker;
        count_t src_count = CNT_RESET;
        count_t dst_count = CNT_RESET;
        logic   discrete  = 1'b0;
        int     errors    = 0;
        mix_t   expected_mix[$];
        int     gain[NCH][NCH];

        task report(string msg);
            errors++;
            if (errors <= 20)
                $display("ERROR @%0t: %s", $time, msg);
        endtask

        function void write_reg(reg_idx_t idx, count_t data);
            case (idx)
                REG_SRC_CH:   src_count = data;
                REG_DST_CH:   dst_count = data;
                REG_DISCRETE: discrete  = data[0];
                default: ;
            endcase
        endfunction

        function void load_gains(int ns, int nd);
            bit speaker;
            speaker = !discrete && ns != nd;
            foreach (gain[d, s])
                gain[d][s] = 0;
            if (speaker)
            begin
                case ({count_t'(ns), count_t'(nd)})
                    {MONO, STEREO}, {MONO, QUAD}:
                    begin
                        gain[0][0] = Q15_ONE;
                        gain[1][0] = Q15_ONE;
                    end
                    {MONO, SURR51}:
                        gain[2][0] = Q15_ONE;
                    {STEREO, QUAD}, {STEREO, SURR51}:
                    begin
                        gain[0][0] = Q15_ONE;
                        gain[1][1] = Q15_ONE;
                    end
                    {QUAD, SURR51}:
                    begin
                        gain[0][0] = Q15_ONE;
                        gain[1][1] = Q15_ONE;
                        gain[4][2] = Q15_ONE;
                        gain[5][3] = Q15_ONE;
                    end
                    {STEREO, MONO}:
                    begin
                        gain[0][0] = Q15_HALF;
                        gain[0][1] = Q15_HALF;
                    end
                    {QUAD, MONO}:
                        for (int s = 0; s < 4; s++)
                            gain[0][s] = Q15_QUARTER;
                    {SURR51, MONO}:
                    begin
                        gain[0][0] = Q15_RSQRT2;
                        gain[0][1] = Q15_RSQRT2;
                        gain[0][2] = Q15_ONE;
                        gain[0][4] = Q15_HALF;
                        gain[0][5] = Q15_HALF;
                    end
                    {QUAD, STEREO}:
                    begin
                        gain[0][0] = Q15_HALF;
                        gain[0][2] = Q15_HALF;
                        gain[1][1] = Q15_HALF;
                        gain[1][3] = Q15_HALF;
                    end
                    {SURR51, STEREO}:
                    begin
                        gain[0][0] = Q15_ONE;
                        gain[0][2] = Q15_RSQRT2;
                        gain[0][4] = Q15_RSQRT2;
                        gain[1][1] = Q15_ONE;
                        gain[1][2] = Q15_RSQRT2;
                        gain[1][5] = Q15_RSQRT2;
                    end
                    {SURR51, QUAD}:
                    begin
                        gain[0][0] = Q15_ONE;
                        gain[0][2] = Q15_RSQRT2;
                        gain[1][1] = Q15_ONE;
                        gain[1][2] = Q15_RSQRT2;
                        gain[2][4] = Q15_ONE;
                        gain[3][5] = Q15_ONE;
                    end
                    default:
                        speaker = 1'b0;
                endcase
            end
            if (!speaker)
                for (int i = 0; i < ns && i < nd; i++)
                    gain[i][i] = Q15_ONE;
        endfunction

        function mix_t mix_frame(frame_t f);
            mix_t   m;
            int     ns;
            int     nd;
            longint acc;
            longint r;
            ns = (src_count > CNT_MAX) ? CNT_MAX : src_count;
            nd = (dst_count > CNT_MAX) ? CNT_MAX : dst_count;
            load_gains(ns, nd);
            m = '0;
            for (int d = 0; d < nd; d++)
            begin
                acc = longint'($signed(f.dst[d])) * Q15_ONE;
                for (int s = 0; s < ns; s++)
                    acc += longint'($signed(f.src[s])) * gain[d][s];
                r = (acc + ROUND_Q15) >>> 15;
                if (r > S24_MAX)
                begin
                    r = S24_MAX;
                    m.clip = 1'b1;
                end
                if (r < S24_MIN)
                begin
                    r = S24_MIN;
                    m.clip = 1'b1;
                end
                m.ch[d] = r[23:0];
            end
            return m;
        endfunction

        function void note_frame(frame_t f);
            expected_mix.push_back(mix_frame(f));
        endfunction

        task check_mix(mix_t got);
            mix_t want;
            if (expected_mix.size() == 0)
            begin
                report("output beat with no frame pending");
                return;
            end
            want = expected_mix.pop_front();
            for (int i = 0; i < NCH; i++)
                if (got.ch[i] !== want.ch[i])
                    report($sformatf("out_ch%0d got %h want %h", i, got.ch[i], want.ch[i]));
            if (got.clip !== want.clip)
                report($sformatf("saturated got %b want %b", got.clip, want.clip));
        endtask

        task flush();
            if (expected_mix.size() != 0)
                report($sformatf("%0d frames never came out", expected_mix.size()));
        endtask
    endclass

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic        in_ready;
    logic        out_valid;
    logic        out_ready   = 1'b0;
    logic        cfg_valid   = 1'b0;
    logic        cfg_ready;
    reg_idx_t    cfg_index   = REG_SRC_CH;
    count_t      cfg_data    = '0;
    frame_t      drive_frame = '0;
    sample_t     out_ch0, out_ch1, out_ch2, out_ch3, out_ch4, out_ch5;
    logic        saturated;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int unsigned cycle_count    = 0;
    mix_checker  book = new();

    mix_setting_t directed_settings [20] = '{
        '{MONO,   STEREO, MODE_SPEAKERS}, '{MONO,   QUAD,   MODE_SPEAKERS},
        '{MONO,   SURR51, MODE_SPEAKERS}, '{STEREO, QUAD,   MODE_SPEAKERS},
        '{STEREO, SURR51, MODE_SPEAKERS}, '{QUAD,   SURR51, MODE_SPEAKERS},
        '{STEREO, MONO,   MODE_SPEAKERS}, '{QUAD,   MONO,   MODE_SPEAKERS},
        '{SURR51, MONO,   MODE_SPEAKERS}, '{QUAD,   STEREO, MODE_SPEAKERS},
        '{SURR51, STEREO, MODE_SPEAKERS}, '{SURR51, QUAD,   MODE_SPEAKERS},
        '{SURR51, SURR51, MODE_SPEAKERS}, '{3'd3,   3'd5,   MODE_SPEAKERS},
        '{SURR51, STEREO, MODE_DISCRETE}, '{MONO,   SURR51, MODE_DISCRETE},
        '{3'd0,   QUAD,   MODE_SPEAKERS}, '{QUAD,   3'd0,   MODE_SPEAKERS},
        '{3'd7,   3'd7,   MODE_SPEAKERS}, '{3'd7,   MONO,   MODE_SPEAKERS}
    };

    audio_channel_up_down_mixer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .src_ch0   (drive_frame.src[0]),
        .src_ch1   (drive_frame.src[1]),
        .src_ch2   (drive_frame.src[2]),
        .src_ch3   (drive_frame.src[3]),
        .src_ch4   (drive_frame.src[4]),
        .src_ch5   (drive_frame.src[5]),
        .dst_ch0   (drive_frame.dst[0]),
        .dst_ch1   (drive_frame.dst[1]),
        .dst_ch2   (drive_frame.dst[2]),
        .dst_ch3   (drive_frame.dst[3]),
        .dst_ch4   (drive_frame.dst[4]),
        .dst_ch5   (drive_frame.dst[5]),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_ch0   (out_ch0),
        .out_ch1   (out_ch1),
        .out_ch2   (out_ch2),
        .out_ch3   (out_ch3),
        .out_ch4   (out_ch4),
        .out_ch5   (out_ch5),
        .saturated (saturated),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL audio_channel_up_down_mixer");
            $finish;
        end
    end

    always @(posedge clk)
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

    // beats are sampled with pre-edge values
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                book.write_reg(cfg_index, cfg_data);
            if (in_valid && in_ready)
                book.note_frame(drive_frame);
            if (out_valid && out_ready)
                book.check_mix(mix_t'({{out_ch5, out_ch4, out_ch3, out_ch2, out_ch1,
                                        out_ch0}, saturated}));
        end
    end

    function automatic sample_t rand_sample();
        case ($urandom_range(0, 9))
            0: return S24_MAX;
            1: return S24_MIN;
            2: return sample_t'(int'($urandom_range(0, 8)) - 4);
            default: return sample_t'($urandom);
        endcase
    endfunction

    function automatic frame_t rand_frame();
        frame_t f;
        for (int i = 0; i < NCH; i++)
        begin
            f.src[i] = rand_sample();
            f.dst[i] = rand_sample();
        end
        return f;
    endfunction

    function automatic frame_t extreme_frame(int k);
        frame_t f;
        for (int i = 0; i < NCH; i++)
        begin
            f.src[i] = k[0] ? S24_MIN : S24_MAX;
            f.dst[i] = k[1] ? S24_MIN : S24_MAX;
        end
        return f;
    endfunction

    function automatic count_t pick_count();
        if ($urandom_range(0, 3) == 0)
            return count_t'($urandom_range(0, 7));
        case ($urandom_range(0, 3))
            0: return MONO;
            1: return STEREO;
            2: return QUAD;
            default: return SURR51;
        endcase
    endfunction

    function automatic mix_setting_t random_setting();
        mix_setting_t s;
        s.src       = pick_count();
        s.dst       = pick_count();
        s.mode_word = {2'($urandom_range(0, 3)), ($urandom_range(0, 3) == 0)};
        return s;
    endfunction

    function automatic void set_idling(int mode);
        case (mode)
            1:
            begin
                send_idle_pct  = 77;
                recv_stall_pct = 0;
            end
            2:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 77;
            end
            3:
            begin
                send_idle_pct  = 15;
                recv_stall_pct = 15;
            end
            default:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
        endcase
    endfunction

    // mid-cycle look so the last accepted beat is already queued
    task automatic wait_drained();
        @(negedge clk);
        while (book.expected_mix.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, count_t data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic apply_setting(mix_setting_t s, bit poke_unused);
        wait_drained();
        write_reg(REG_SRC_CH, s.src);
        write_reg(REG_DST_CH, s.dst);
        write_reg(REG_DISCRETE, s.mode_word);
        if (poke_unused)
            write_reg(REG_UNUSED, count_t'($urandom_range(0, 7)));
        cfg_valid <= 1'b0;
    endtask

    // leaves in_valid high after the beat; caller lowers it at the end of a burst
    task automatic send_frame(frame_t f);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        drive_frame <= f;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    initial
    begin
        int items;
        int n;
        items = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset setting first, then every layout pair and the odd counts
        send_frame(extreme_frame(0));
        send_frame(extreme_frame(3));
        in_valid <= 1'b0;
        items += 2;
        for (int k = 0; k < 20; k++)
        begin
            apply_setting(directed_settings[k], k == 13);
            send_frame(extreme_frame(k));
            in_valid <= 1'b0;
            items++;
        end

        while (items < ITEM_TARGET)
        begin
            apply_setting(random_setting(), $urandom_range(0, 4) == 0);
            set_idling($urandom_range(0, 3));
            n = $urandom_range(4, 24);
            repeat (n) send_frame(rand_frame());
            in_valid <= 1'b0;
            items += n;
        end

        wait_drained();
        book.flush();
        if (book.errors == 0)
            $display("PASS audio_channel_up_down_mixer");
        else
            $display("FAIL audio_channel_up_down_mixer");
        $finish;
    end

endmodule
